// ===== hw/rtl/mbrc_pkg.sv =====
// Shared types, codes and the CRC byte step for the Modbus reply checker.
// No dependencies; the channel interfaces and the top level use this package.
package mbrc_pkg;

  localparam int unsigned REQ_W     = 2;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned READING_W = 32;
  localparam int unsigned COUNT_W   = 8;
  localparam int unsigned POS_W     = 4;
  localparam int unsigned CRC_W     = 16;
  localparam int unsigned CFG_IDX_W = 1;

  typedef logic [REQ_W-1:0]     req_t;
  typedef logic [BYTE_W-1:0]    byte_t;
  typedef logic [STATUS_W-1:0]  status_t;
  typedef logic [READING_W-1:0] reading_t;
  typedef logic [COUNT_W-1:0]   count_t;
  typedef logic [POS_W-1:0]     pos_t;
  typedef logic [CRC_W-1:0]     crc_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Request codes
  localparam req_t REQ_START   = 2'd0;
  localparam req_t REQ_BYTE    = 2'd1;
  localparam req_t REQ_TIMEOUT = 2'd2;

  // Result status codes
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_SHORT     = 2'd1;
  localparam status_t ST_HDR_ERR   = 2'd2;
  localparam status_t ST_CRC_ERR   = 2'd3;

  // Configuration register indexes
  localparam cfg_idx_t CFG_SLAVE_ADDR = 1'd0;
  localparam cfg_idx_t CFG_FAIL_LIMIT = 1'd1;

  localparam byte_t  SLAVE_ADDR_RESET = 8'd1;
  localparam count_t FAIL_LIMIT_RESET = 8'd20;

  localparam crc_t  CRC_INIT   = 16'hFFFF;
  localparam crc_t  CRC_POLY   = 16'hA001;
  localparam byte_t FUNC_CODE  = 8'h03;
  localparam byte_t BYTE_COUNT = 8'h04;
  localparam pos_t  FRAME_LEN  = 4'd9;
  localparam pos_t  CRC_SPAN   = 4'd7;
  localparam count_t COUNT_MAX = 8'hFF;

  // CRC-16/Modbus over one byte, reflected, LSB first
  function automatic crc_t crc_feed(input crc_t crc_in, input byte_t b);
    crc_t c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/mbrc_in_if.sv =====
// Input channel for the Modbus reply checker: request code and received byte.
// Depends on mbrc_pkg.
interface mbrc_in_if;
  logic            valid;
  logic            ready;
  mbrc_pkg::req_t  req_type;
  mbrc_pkg::byte_t data_byte;

  modport source (output valid, output req_type, output data_byte, input ready);
  modport sink   (input valid, input req_type, input data_byte, output ready);
endinterface

// ===== hw/rtl/mbrc_out_if.sv =====
// Result channel for the Modbus reply checker.
// Depends on mbrc_pkg.
interface mbrc_out_if;
  logic               valid;
  logic               ready;
  mbrc_pkg::status_t  status;
  mbrc_pkg::reading_t reading;
  logic               recover;
  mbrc_pkg::count_t   failures_so_far;

  modport source (output valid, output status, output reading, output recover,
                  output failures_so_far, input ready);
  modport sink   (input valid, input status, input reading, input recover,
                  input failures_so_far, output ready);
endinterface

// ===== hw/rtl/mbrc_cfg_if.sv =====
// Configuration write channel for the Modbus reply checker.
// Depends on mbrc_pkg.
interface mbrc_cfg_if;
  logic                valid;
  logic                ready;
  mbrc_pkg::cfg_idx_t  index;
  mbrc_pkg::byte_t     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/modbus_read_response_checker.sv =====
// Top level of the Modbus RTU read-holding-registers reply checker.
// Depends on mbrc_pkg and the mbrc_in_if, mbrc_out_if and mbrc_cfg_if interfaces.
//
// Takes one item per cycle while the result side keeps taking results: an
// accepted item lands in an input register, is checked against the frame
// state by a single pass of logic (one CRC byte step, header compares and the
// failure counter), and any result goes to an output register. Configuration
// writes are always accepted.
module modbus_read_response_checker (
  input logic        clk,
  input logic        rst_n,
  mbrc_in_if.sink    in_ch,
  mbrc_out_if.source out_ch,
  mbrc_cfg_if.sink   cfg_ch
);

  // configuration
  mbrc_pkg::byte_t  slave_addr_r;
  mbrc_pkg::count_t fail_limit_r;

  // input register
  logic             s1_valid_r;
  mbrc_pkg::req_t   s1_req_r;
  mbrc_pkg::byte_t  s1_byte_r;

  // frame state
  logic               awaiting_r,   awaiting_nxt;
  mbrc_pkg::pos_t     pos_r,        pos_nxt;
  mbrc_pkg::crc_t     crc_r,        crc_nxt;
  logic               hdr_good_r,   hdr_good_nxt;
  logic               crc_lo_ok_r,  crc_lo_ok_nxt;
  mbrc_pkg::reading_t value_r,      value_nxt;
  mbrc_pkg::count_t   fail_cnt_r,   fail_cnt_nxt;

  // result register
  logic               out_valid_r;
  mbrc_pkg::status_t  out_status_r,  res_status;
  mbrc_pkg::reading_t out_reading_r, res_reading;
  logic               out_recover_r, res_recover;
  mbrc_pkg::count_t   out_fails_r;
  logic               res_valid;

  logic               advance;
  logic               open_frame;
  mbrc_pkg::count_t   cnt_inc;

  assign advance     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || advance;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = out_status_r;
  assign out_ch.reading         = out_reading_r;
  assign out_ch.recover         = out_recover_r;
  assign out_ch.failures_so_far = out_fails_r;

  assign open_frame = awaiting_r && (pos_r < mbrc_pkg::FRAME_LEN);
  assign cnt_inc    = (fail_cnt_r == mbrc_pkg::COUNT_MAX) ? fail_cnt_r
                                                          : fail_cnt_r + 8'd1;

  always_comb begin
    awaiting_nxt  = awaiting_r;
    pos_nxt       = pos_r;
    crc_nxt       = crc_r;
    hdr_good_nxt  = hdr_good_r;
    crc_lo_ok_nxt = crc_lo_ok_r;
    value_nxt     = value_r;
    fail_cnt_nxt  = fail_cnt_r;
    res_valid     = 1'b0;
    res_status    = mbrc_pkg::ST_OK;
    res_reading   = '0;
    res_recover   = 1'b0;

    if (s1_valid_r) begin
      unique case (s1_req_r)
        mbrc_pkg::REQ_START: begin
          awaiting_nxt  = 1'b1;
          pos_nxt       = '0;
          crc_nxt       = mbrc_pkg::CRC_INIT;
          hdr_good_nxt  = 1'b1;
          crc_lo_ok_nxt = 1'b0;
          value_nxt     = '0;
        end
        mbrc_pkg::REQ_TIMEOUT: begin
          if (open_frame) begin
            res_valid  = 1'b1;
            res_status = mbrc_pkg::ST_SHORT;
          end
        end
        mbrc_pkg::REQ_BYTE: begin
          if (open_frame) begin
            pos_nxt = pos_r + 4'd1;
            if (pos_r < mbrc_pkg::CRC_SPAN) begin
              crc_nxt = mbrc_pkg::crc_feed(crc_r, s1_byte_r);
              priority if (pos_r == 4'd0) begin
                hdr_good_nxt = hdr_good_r && (s1_byte_r == slave_addr_r);
              end else if (pos_r == 4'd1) begin
                hdr_good_nxt = hdr_good_r && (s1_byte_r == mbrc_pkg::FUNC_CODE);
              end else if (pos_r == 4'd2) begin
                hdr_good_nxt = hdr_good_r && (s1_byte_r == mbrc_pkg::BYTE_COUNT);
              end else begin
                value_nxt = {value_r[23:0], s1_byte_r};
              end
            end else if (pos_r == mbrc_pkg::CRC_SPAN) begin
              crc_lo_ok_nxt = (s1_byte_r == crc_r[7:0]);
            end else begin
              res_valid = 1'b1;
              priority if (!hdr_good_r) begin
                res_status = mbrc_pkg::ST_HDR_ERR;
              end else if (!crc_lo_ok_r || (s1_byte_r != crc_r[15:8])) begin
                res_status = mbrc_pkg::ST_CRC_ERR;
              end else begin
                res_status  = mbrc_pkg::ST_OK;
                res_reading = value_r;
              end
            end
          end
        end
        default: ;
      endcase

      // closing a frame updates the consecutive-failure count
      if (res_valid) begin
        awaiting_nxt = 1'b0;
        if (res_status == mbrc_pkg::ST_OK) begin
          fail_cnt_nxt = '0;
        end else if (cnt_inc >= fail_limit_r) begin
          res_recover  = 1'b1;
          fail_cnt_nxt = '0;
        end else begin
          fail_cnt_nxt = cnt_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_addr_r <= mbrc_pkg::SLAVE_ADDR_RESET;
      fail_limit_r <= mbrc_pkg::FAIL_LIMIT_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        mbrc_pkg::CFG_SLAVE_ADDR: slave_addr_r <= cfg_ch.data;
        mbrc_pkg::CFG_FAIL_LIMIT: fail_limit_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_req_r  <= in_ch.req_type;
      s1_byte_r <= in_ch.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_r  <= 1'b0;
      pos_r       <= '0;
      crc_r       <= mbrc_pkg::CRC_INIT;
      hdr_good_r  <= 1'b1;
      crc_lo_ok_r <= 1'b0;
      value_r     <= '0;
      fail_cnt_r  <= '0;
    end else if (advance) begin
      awaiting_r  <= awaiting_nxt;
      pos_r       <= pos_nxt;
      crc_r       <= crc_nxt;
      hdr_good_r  <= hdr_good_nxt;
      crc_lo_ok_r <= crc_lo_ok_nxt;
      value_r     <= value_nxt;
      fail_cnt_r  <= fail_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_status_r  <= res_status;
      out_reading_r <= res_reading;
      out_recover_r <= res_recover;
      out_fails_r   <= fail_cnt_nxt;
    end
  end

endmodule
